[rtl/dpwp_pkg.sv]
package dpwp_pkg;

	localparam int CoordBitsDefault = 12;

	typedef enum logic [2:0] {
		REG_MODE        = 3'd0,
		REG_INV_FOCAL   = 3'd1,
		REG_PRINCIPAL   = 3'd2,
		REG_ROT0        = 3'd3,
		REG_ROT1        = 3'd4,
		REG_ROT2        = 3'd5,
		REG_TRANSLATION = 3'd6
	} reg_index_t;

	localparam logic [53:0] Rot0Reset = 54'd65536;
	localparam logic [53:0] Rot1Reset = 54'd65536 << 18;
	localparam logic [53:0] Rot2Reset = 54'd65536 << 36;

	typedef struct packed {
		logic [31:0] depth_value;
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [7:0]         point_red;
		logic [7:0]         point_green;
		logic [7:0]         point_blue;
	} point_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [47:0] inverse_focal;
		logic [31:0] principal_point;
		logic [53:0] rot0;
		logic [53:0] rot1;
		logic [53:0] rot2;
		logic [62:0] translation;
	} cfg_t;

endpackage

[rtl/depth_pixel_to_world_point_core.sv]
// Pipeline from start to strobe: depth decode, projection, rigid transform.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls.
// Results cannot be held off by the receiver; dropped pixels give no strobe.
// Reset (arst_n low) clears all valid bits and loads register defaults
// (identity rotation, color off, millimeter depth).
module depth_pixel_to_world_point_core #(
	parameter int COORD_BITS = dpwp_pkg::CoordBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dpwp_pkg::pixel_t  pixel,
	output logic              strobe,
	output dpwp_pkg::point_t  point,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import dpwp_pkg::*;

	localparam int Lat = 8;
	localparam logic [11:0] CoordMask = 12'((32'd1 << COORD_BITS) - 32'd1);

	cfg_t cfg_q;
	logic accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= '0;
			cfg_q.inverse_focal   <= '0;
			cfg_q.principal_point <= '0;
			cfg_q.rot0            <= Rot0Reset;
			cfg_q.rot1            <= Rot1Reset;
			cfg_q.rot2            <= Rot2Reset;
			cfg_q.translation     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_MODE:        cfg_q.mode            <= cfg_data[1:0];
				REG_INV_FOCAL:   cfg_q.inverse_focal   <= cfg_data[47:0];
				REG_PRINCIPAL:   cfg_q.principal_point <= cfg_data[31:0];
				REG_ROT0:        cfg_q.rot0            <= cfg_data[53:0];
				REG_ROT1:        cfg_q.rot1            <= cfg_data[53:0];
				REG_ROT2:        cfg_q.rot2            <= cfg_data[53:0];
				REG_TRANSLATION: cfg_q.translation     <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	// pixel delay line for coordinates and color
	logic [11:0] col_q [2];
	logic [11:0] row_q [2];
	logic [23:0] rgb_q [Lat];

	always_ff @(posedge clk) begin
		col_q[0] <= pixel.pixel_col;
		row_q[0] <= pixel.pixel_row;
		col_q[1] <= col_q[0];
		row_q[1] <= row_q[0];
		rgb_q[0] <= {pixel.red_in, pixel.green_in, pixel.blue_in};
		for (int i = 1; i < Lat; i++)
			rgb_q[i] <= rgb_q[i-1];
	end

	// depth decode
	logic               dv;
	logic signed [32:0] depth;

	dpwp_depth u_depth (
		.clk, .arst_n,
		.mode_float(cfg_q.mode[0]),
		.in_valid(accept),
		.raw(pixel.depth_value),
		.out_valid(dv),
		.depth
	);

	// mask coordinates, offset by the principal point in Q12.4
	logic [11:0]        cu, cv;
	logic signed [16:0] du, dvv;
	assign cu  = col_q[1] & CoordMask;
	assign cv  = row_q[1] & CoordMask;
	assign du  = $signed({1'b0, cu, 4'd0}) - $signed({1'b0, cfg_q.principal_point[15:0]});
	assign dvv = $signed({1'b0, cv, 4'd0}) - $signed({1'b0, cfg_q.principal_point[31:16]});

	// projection, four stages; depth and valid delayed alongside
	logic signed [31:0] camx, camy;
	logic               ovx, ovy;
	logic signed [32:0] dz_q [4];
	logic [3:0]         pv_q;

	dpwp_project u_px (.clk, .delta(du), .inv(cfg_q.inverse_focal[23:0]),
		.depth, .coord(camx), .ovf(ovx));
	dpwp_project u_py (.clk, .delta(dvv), .inv(cfg_q.inverse_focal[47:24]),
		.depth, .coord(camy), .ovf(ovy));

	always_ff @(posedge clk) begin
		dz_q[0] <= depth;
		for (int i = 1; i < 4; i++)
			dz_q[i] <= dz_q[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else begin
			pv_q <= {pv_q[2:0], dv};
		end
	end

	// rigid transform, two stages
	logic signed [31:0] wx, wy, wz;
	logic               owx, owy, owz;
	logic [1:0]         tv_q;
	logic [1:0]         cov_q;

	dpwp_rotate u_rx (.clk, .row(cfg_q.rot0), .trans(cfg_q.translation[20:0]),
		.cx(camx), .cy(camy), .cz(dz_q[3]), .coord(wx), .ovf(owx));
	dpwp_rotate u_ry (.clk, .row(cfg_q.rot1), .trans(cfg_q.translation[41:21]),
		.cx(camx), .cy(camy), .cz(dz_q[3]), .coord(wy), .ovf(owy));
	dpwp_rotate u_rz (.clk, .row(cfg_q.rot2), .trans(cfg_q.translation[62:42]),
		.cx(camx), .cy(camy), .cz(dz_q[3]), .coord(wz), .ovf(owz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_q <= '0;
		end else begin
			tv_q <= {tv_q[0], pv_q[3]};
		end
	end

	always_ff @(posedge clk) begin
		cov_q <= {cov_q[0], ovx || ovy};
	end

	// output
	assign strobe = tv_q[1] && !cov_q[1] && !owx && !owy && !owz;

	always_comb begin
		point.point_x = wx;
		point.point_y = wy;
		point.point_z = wz;
		if (cfg_q.mode[1]) begin
			point.point_red   = rgb_q[Lat-1][23:16];
			point.point_green = rgb_q[Lat-1][15:8];
			point.point_blue  = rgb_q[Lat-1][7:0];
		end else begin
			point.point_red   = 8'hFF;
			point.point_green = 8'hFF;
			point.point_blue  = 8'hFF;
		end
	end
endmodule

[rtl/dpwp_depth.sv]
// Depth decode: raw millimeters or float meters to signed Q16.16.
// Two register stages; the millimeter path uses a reciprocal multiply.
module dpwp_depth (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mode_float,
	input  logic                in_valid,
	input  logic [31:0]         raw,
	output logic                out_valid,
	output logic signed [32:0]  depth
);
	import dpwp_pkg::*;

	// d = floor((mm*65536+500)/1000); numerator < 2^32, divide by 1000 via
	// multiply by ceil(2^41/1000) = 2199023256 (exact for numerator < 2^32)
	localparam logic [31:0] Recip1000 = 32'd2199023256;

	logic        v_s1;
	logic        keep_s1;
	logic        float_s1;
	logic [31:0] num_s1;
	logic        neg_s1;
	logic [31:0] fq_s1;

	logic [15:0] mm;
	logic [7:0]  ex;
	logic [23:0] man;
	logic [31:0] fq;
	logic        fkeep;
	logic [4:0]  rs;
	logic [2:0]  ls;
	logic [63:0] prod;

	always_comb begin
		mm    = raw[15:0];
		ex    = raw[30:23];
		man   = {1'b1, raw[22:0]};
		fq    = '0;
		fkeep = 1'b1;
		rs    = '0;
		ls    = '0;
		if (ex == 8'hFF) begin
			fkeep = 1'b0;
		end else if (ex == 8'd0) begin
			fq = '0;
		end else if (ex >= 8'd134) begin
			if (ex >= 8'd142) begin
				fkeep = 1'b0;
			end else begin
				ls = 3'(ex - 8'd134);
				fq = 32'(man) << ls;
			end
		end else if ((8'd134 - ex) > 8'd25) begin
			fq = '0;
		end else begin
			rs = 5'(8'd134 - ex);
			fq = (32'(man) + (32'd1 << (rs - 5'd1))) >> rs;
		end
		if (fq[31])
			fkeep = 1'b0;
	end

	// stage 1: classify and form numerator or float magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		float_s1 <= mode_float;
		keep_s1  <= mode_float ? fkeep : (mm != 16'd0);
		num_s1   <= {mm, 16'd0} + 32'd500;
		neg_s1   <= raw[31];
		fq_s1    <= fq;
	end

	assign prod = num_s1 * Recip1000;

	// stage 2: finish scaling and apply sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1 && keep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (float_s1)
			depth <= neg_s1 ? -$signed({1'b0, fq_s1}) : $signed({1'b0, fq_s1});
		else
			depth <= $signed({10'd0, prod[63:41]});
	end
endmodule

[rtl/dpwp_project.sv]
// Back-projection of one axis: round(delta*inv*d / 2^28), with range check.
// Register stages: delta*inv, magnitudes, partial products, rounded sum.
module dpwp_project (
	input  logic               clk,
	input  logic signed [16:0] delta,
	input  logic [23:0]        inv,
	input  logic signed [32:0] depth,
	output logic signed [31:0] coord,
	output logic               ovf
);
	import dpwp_pkg::*;

	logic signed [41:0] a_s1;
	logic signed [32:0] d_s1;
	logic [40:0]        ma_s2;
	logic [15:0]        hi_s2;
	logic [15:0]        lo_s2;
	logic               neg_s2;
	logic [56:0]        t_s3;
	logic [56:0]        l_s3;
	logic               neg_s3;
	logic [40:0]        ma;
	logic [31:0]        md;
	logic [57:0]        q;
	logic signed [58:0] sq;

	// form delta*inv
	always_ff @(posedge clk) begin
		a_s1 <= delta * $signed({1'b0, inv});
		d_s1 <= depth;
	end

	assign ma = a_s1[41] ? 41'(-a_s1) : 41'(a_s1);
	assign md = d_s1[32] ? 32'(-d_s1) : 32'(d_s1);

	always_ff @(posedge clk) begin
		ma_s2  <= ma;
		hi_s2  <= md[31:16];
		lo_s2  <= md[15:0];
		neg_s2 <= (a_s1[41] != d_s1[32]) && (a_s1 != 0) && (d_s1 != 0);
	end

	// partial products
	always_ff @(posedge clk) begin
		t_s3   <= ma_s2 * hi_s2;
		l_s3   <= ma_s2 * lo_s2;
		neg_s3 <= neg_s2;
	end

	always_comb begin
		q  = 58'(t_s3 >> 12) +
		     58'(({1'b0, t_s3[11:0], 16'd0} + 58'(l_s3) + (58'd1 << 27)) >> 28);
		sq = neg_s3 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	end

	always_ff @(posedge clk) begin
		coord <= sq[31:0];
		ovf   <= (sq > 59'sd2147483647) || (sq < -59'sd2147483648);
	end
endmodule

[rtl/dpwp_rotate.sv]
// One world coordinate: row dot camera point, round by 2^16, add t*32.
// Two register stages: three products, then sum and range check.
module dpwp_rotate (
	input  logic               clk,
	input  logic [53:0]        row,
	input  logic signed [20:0] trans,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	input  logic signed [32:0] cz,
	output logic signed [31:0] coord,
	output logic               ovf
);
	import dpwp_pkg::*;

	logic signed [50:0] p0_s1;
	logic signed [50:0] p1_s1;
	logic signed [50:0] p2_s1;
	logic signed [20:0] t_s1;
	logic signed [52:0] acc;
	logic [52:0]        m;
	logic [36:0]        r;
	logic signed [38:0] v;

	// products
	always_ff @(posedge clk) begin
		p0_s1 <= $signed(row[17:0]) * cx;
		p1_s1 <= $signed(row[35:18]) * cy;
		p2_s1 <= $signed(row[53:36]) * cz;
		t_s1  <= trans;
	end

	always_comb begin
		acc = 53'(p0_s1) + 53'(p1_s1) + 53'(p2_s1);
		m   = acc[52] ? 53'(-acc) : 53'(acc);
		r   = 37'((m + 53'd32768) >> 16);
		v   = (acc[52] ? -$signed({2'b0, r}) : $signed({2'b0, r})) +
		      39'(t_s1) * 39'sd32;
	end

	always_ff @(posedge clk) begin
		coord <= v[31:0];
		ovf   <= (v > 39'sd2147483647) || (v < -39'sd2147483648);
	end
endmodule

[rtl/dpwp_checker.sv]
module dpwp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             strobe,
	input dpwp_pkg::point_t point,
	input logic             cfg_valid,
	input logic             cfg_ready
);
	import dpwp_pkg::*;

	// never stall input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// no result without an earlier pixel start
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start, 8))
		else $error("strobe without item");

	// register writes are never held off
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config stalled");

	// no strobe right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !strobe)
		else $error("strobe out of reset");

	// a strobed item carries known data
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !$isunknown(point))
		else $error("unknown point on strobe");
endmodule

bind depth_pixel_to_world_point_core dpwp_checker u_chk (
	.clk, .arst_n, .start, .busy, .strobe, .point, .cfg_valid, .cfg_ready
);
